@@ hdl/adsr_pkg.sv @@
// types, constants and codes shared by the adsr envelope generator
package adsr_pkg;

  // amplitude format: unsigned q1.frac
  localparam int AMP_FRAC_BITS = 16;
  localparam int AMP_BITS      = AMP_FRAC_BITS + 1;
  localparam logic [AMP_BITS-1:0] AMP_ONE = AMP_BITS'(1) << AMP_FRAC_BITS;

  // duration registers and time stamps
  localparam int TICK_BITS      = 24;
  localparam int TIME_TICK_BITS = 32;
  localparam int TIME_BITS_DEF  = 32;

  // configuration port
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 24;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ATTACK  = 2'd0,
    REG_DECAY   = 2'd1,
    REG_SUSTAIN = 2'd2,
    REG_RELEASE = 2'd3
  } cfg_reg_t;

  // reset values of the configuration registers
  localparam logic [TICK_BITS-1:0] ATTACK_RST  = 24'd441;
  localparam logic [TICK_BITS-1:0] DECAY_RST   = 24'd441;
  localparam logic [AMP_BITS-1:0]  SUSTAIN_RST = 17'd52429;
  localparam logic [TICK_BITS-1:0] RELEASE_RST = 24'd441;

  // function codes of an input item
  localparam logic [1:0] FUNC_QUERY    = 2'd0;
  localparam logic [1:0] FUNC_NOTE_ON  = 2'd1;
  localparam logic [1:0] FUNC_NOTE_OFF = 2'd2;

  // envelope segments
  typedef enum logic [2:0] {
    SEG_ATTACK  = 3'd0,
    SEG_DECAY   = 3'd1,
    SEG_SUSTAIN = 3'd2,
    SEG_RELEASE = 3'd3,
    SEG_SILENT  = 3'd4
  } segment_t;

  // input item
  typedef struct packed {
    logic [1:0]                func;
    logic [TIME_TICK_BITS-1:0] time_tick;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [AMP_BITS-1:0] amplitude;
    logic [2:0]          segment;
  } out_item_t;

endpackage

@@ hdl/adsr_envelope_generator_unit.sv @@
// adsr envelope generator: state update, segment select and serial scaled divider
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready  | in_data   (func, time_tick)
//  out     | output    | out_valid / out_ready| out_data  (amplitude, segment)
//  cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// an item passes from acceptance through time differences, range compares and segment
// select, then the bit-serial multiply-divide unit, one amplitude bit per step, and
// last the load of the output register. the next item is accepted the cycle after that
// load at the earliest: no item is taken before the last one is loaded. rst_n is
// synchronous and clears control state, the note state and the configuration registers
// to their defaults. a result waits in the output register while the next item is
// accepted; a stalled result holds the unit in its last state.
module adsr_envelope_generator_unit #(
  parameter int TIME_BITS = adsr_pkg::TIME_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  adsr_pkg::in_item_t                      in_data,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output adsr_pkg::out_item_t                     out_data,
  input  logic                                    cfg_we,
  input  logic [adsr_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [adsr_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

  localparam int AB  = adsr_pkg::AMP_BITS;
  localparam int TB  = adsr_pkg::TICK_BITS;
  localparam int IW  = (TIME_BITS > adsr_pkg::TIME_TICK_BITS) ?
                       TIME_BITS : adsr_pkg::TIME_TICK_BITS;
  localparam int EW  = (TIME_BITS > TB) ? TIME_BITS : TB;
  localparam int XW  = TB + 3;
  localparam int CW  = $clog2(AB + 1);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_DIFF = 6'b000010,
    ST_CMP  = 6'b000100,
    ST_SEL  = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  state_t                state_r, state_nxt;

  // configuration registers
  logic [TB-1:0]         attack_r, decay_r, release_r;
  logic [AB-1:0]         sustain_r;

  // note state
  logic [TIME_BITS-1:0]  on_time_r, off_time_r;
  logic                  held_r;

  // datapath registers
  logic [TIME_BITS-1:0]  t_r, life_r, since_off_r;
  logic [EW:0]           la_r, rmr_r;
  adsr_pkg::segment_t    seg_r;
  logic [AB-1:0]         a_r, q_r;
  logic [TB-1:0]         b_r, div_r, rem_r;
  logic [CW-1:0]         cnt_r;
  logic                  out_valid_r;
  adsr_pkg::out_item_t   out_data_r;

  logic                  in_acc;
  logic                  out_load;
  logic [IW-1:0]         t_ext;
  logic [TIME_BITS-1:0]  t_in;
  logic [EW-1:0]         life_ext, since_ext;
  logic [EW:0]           lad;
  logic [XW-1:0]         x, d1, d2;
  logic [AB-1:0]         amp;
  logic [AB-1:0]         sus_in;
  logic [TB-1:0]         dur_in;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // time stamp cut or widened to TIME_BITS
  assign t_ext = IW'(in_data.time_tick);
  assign t_in  = t_ext[TIME_BITS-1:0];

  // config write values: zero duration reads as one, sustain saturates at full scale
  assign dur_in = (cfg_data[TB-1:0] == '0) ? TB'(1) : cfg_data[TB-1:0];
  assign sus_in = (cfg_data[AB-1:0] > adsr_pkg::AMP_ONE) ? adsr_pkg::AMP_ONE :
                  cfg_data[AB-1:0];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_r  <= adsr_pkg::ATTACK_RST;
      decay_r   <= adsr_pkg::DECAY_RST;
      sustain_r <= adsr_pkg::SUSTAIN_RST;
      release_r <= adsr_pkg::RELEASE_RST;
    end else if (cfg_we) begin
      unique case (adsr_pkg::cfg_reg_t'(cfg_index))
        adsr_pkg::REG_ATTACK:  attack_r  <= dur_in;
        adsr_pkg::REG_DECAY:   decay_r   <= dur_in;
        adsr_pkg::REG_SUSTAIN: sustain_r <= sus_in;
        adsr_pkg::REG_RELEASE: release_r <= dur_in;
        default: ;
      endcase
    end
  end

  // note state update on an accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_time_r  <= '0;
      off_time_r <= '0;
      held_r     <= 1'b0;
    end else if (in_acc) begin
      case (in_data.func)
        adsr_pkg::FUNC_NOTE_ON: begin
          on_time_r <= t_in;
          held_r    <= 1'b1;
        end
        adsr_pkg::FUNC_NOTE_OFF: begin
          off_time_r <= t_in;
          held_r     <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_DIFF;
      ST_DIFF: state_nxt = ST_CMP;
      ST_CMP:  state_nxt = ST_SEL;
      ST_SEL:  state_nxt = ST_DIV;
      ST_DIV:  if (cnt_r == CW'(1)) state_nxt = ST_DONE;
      ST_DONE: if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // elapsed times widened for the compares
  assign life_ext  = EW'(life_r);
  assign since_ext = EW'(since_off_r);
  assign lad       = {1'b0, la_r[EW-1:0]} - (EW + 1)'(decay_r);

  // multiply-divide step: x = 2*rem + bit*b, then take off D or 2*D where it fits
  assign x  = {2'b00, rem_r, 1'b0} + (a_r[AB-1] ? XW'(b_r) : '0);
  assign d1 = x - XW'(div_r);
  assign d2 = x - XW'({div_r, 1'b0});

  // time differences, segment select and serial unit
  always_ff @(posedge clk) begin
    if (in_acc) t_r <= t_in;
    unique case (state_r)
      ST_DIFF: begin
        life_r      <= t_r - on_time_r;
        since_off_r <= t_r - off_time_r;
      end
      ST_CMP: begin
        la_r  <= {1'b0, life_ext} - (EW + 1)'(attack_r);
        rmr_r <= {1'b0, since_ext} - (EW + 1)'(release_r);
      end
      ST_SEL: begin
        rem_r <= '0;
        q_r   <= '0;
        cnt_r <= CW'(AB);
        if (la_r[EW]) begin
          // attack: life * one / attack
          seg_r <= adsr_pkg::SEG_ATTACK;
          a_r   <= adsr_pkg::AMP_ONE;
          b_r   <= life_ext[TB-1:0];
          div_r <= attack_r;
        end else if (lad[EW]) begin
          // decay: (one - sustain) * (life - attack) / decay
          seg_r <= adsr_pkg::SEG_DECAY;
          a_r   <= adsr_pkg::AMP_ONE - sustain_r;
          b_r   <= la_r[TB-1:0];
          div_r <= decay_r;
        end else if (held_r) begin
          seg_r <= adsr_pkg::SEG_SUSTAIN;
          a_r   <= '0;
          b_r   <= '0;
          div_r <= release_r;
        end else if (rmr_r[EW]) begin
          // release: sustain * (release - since_off) / release
          seg_r <= adsr_pkg::SEG_RELEASE;
          a_r   <= sustain_r;
          b_r   <= release_r - since_ext[TB-1:0];
          div_r <= release_r;
        end else begin
          seg_r <= adsr_pkg::SEG_SILENT;
          a_r   <= '0;
          b_r   <= '0;
          div_r <= release_r;
        end
      end
      ST_DIV: begin
        a_r   <= {a_r[AB-2:0], 1'b0};
        cnt_r <= cnt_r - CW'(1);
        if (!d2[XW-1]) begin
          rem_r <= d2[TB-1:0];
          q_r   <= {q_r[AB-2:0], 1'b0} + AB'(2);
        end else if (!d1[XW-1]) begin
          rem_r <= d1[TB-1:0];
          q_r   <= {q_r[AB-2:0], 1'b0} + AB'(1);
        end else begin
          rem_r <= x[TB-1:0];
          q_r   <= {q_r[AB-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  // amplitude from the quotient by segment
  always_comb begin
    case (seg_r)
      adsr_pkg::SEG_ATTACK:  amp = q_r;
      adsr_pkg::SEG_DECAY:   amp = adsr_pkg::AMP_ONE - q_r;
      adsr_pkg::SEG_SUSTAIN: amp = sustain_r;
      adsr_pkg::SEG_RELEASE: amp = q_r;
      default:               amp = '0;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.amplitude <= amp;
      out_data_r.segment   <= seg_r;
    end
  end

endmodule

@@ bench/adsr_envelope_generator_unit_tb.sv @@
// testbench for the adsr envelope generator: random and directed items checked against a predictor
`timescale 1ns / 100ps

module adsr_envelope_generator_unit_tb;

  // spare function code, handled as a query
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  // envelope predictor and store of expected levels
  class envelope_scoreboard;
    longint unsigned attack_len, decay_len, sustain_amp, release_len;
    logic [adsr_pkg::TIME_BITS_DEF-1:0] on_stamp, off_stamp;
    bit note_held;
    adsr_pkg::out_item_t expected_levels[$];
    int unsigned items_in, results_ok, mismatches;
    int unsigned seg_seen[5];

    function new();
      attack_len  = adsr_pkg::ATTACK_RST;
      decay_len   = adsr_pkg::DECAY_RST;
      sustain_amp = adsr_pkg::SUSTAIN_RST;
      release_len = adsr_pkg::RELEASE_RST;
      on_stamp    = '0;
      off_stamp   = '0;
      note_held   = 1'b0;
    endfunction

    // a zero duration acts as one tick
    function longint unsigned duration_of(logic [adsr_pkg::CFG_DATA_BITS-1:0] d);
      return (d[adsr_pkg::TICK_BITS-1:0] == '0) ? 1 :
             longint'(d[adsr_pkg::TICK_BITS-1:0]);
    endfunction

    function void write_reg(adsr_pkg::cfg_reg_t idx, logic [adsr_pkg::CFG_DATA_BITS-1:0] d);
      longint unsigned s;
      case (idx)
        adsr_pkg::REG_ATTACK: attack_len = duration_of(d);
        adsr_pkg::REG_DECAY:  decay_len = duration_of(d);
        adsr_pkg::REG_SUSTAIN: begin
          // only the amplitude bits count, saturated at full scale
          s = d[adsr_pkg::AMP_BITS-1:0];
          sustain_amp = (s > adsr_pkg::AMP_ONE) ? longint'(adsr_pkg::AMP_ONE) : s;
        end
        adsr_pkg::REG_RELEASE: release_len = duration_of(d);
        default: ;
      endcase
    endfunction

    // update note state and work out the level at the item's time stamp
    function void note_input(adsr_pkg::in_item_t it);
      logic [adsr_pkg::TIME_BITS_DEF-1:0] stamp, life, since_off;
      longint unsigned lf, so, amp, one;
      adsr_pkg::segment_t seg;
      adsr_pkg::out_item_t lvl;
      one = adsr_pkg::AMP_ONE;
      stamp = it.time_tick[adsr_pkg::TIME_BITS_DEF-1:0];
      if (it.func == adsr_pkg::FUNC_NOTE_ON) begin
        on_stamp = stamp;
        note_held = 1'b1;
      end else if (it.func == adsr_pkg::FUNC_NOTE_OFF) begin
        off_stamp = stamp;
        note_held = 1'b0;
      end
      life = stamp - on_stamp;
      since_off = stamp - off_stamp;
      lf = life;
      so = since_off;
      if (lf < attack_len) begin
        amp = (lf * one) / attack_len;
        seg = adsr_pkg::SEG_ATTACK;
      end else if (lf < attack_len + decay_len) begin
        amp = one - ((one - sustain_amp) * (lf - attack_len)) / decay_len;
        seg = adsr_pkg::SEG_DECAY;
      end else if (note_held) begin
        amp = sustain_amp;
        seg = adsr_pkg::SEG_SUSTAIN;
      end else if (so < release_len) begin
        amp = (sustain_amp * (release_len - so)) / release_len;
        seg = adsr_pkg::SEG_RELEASE;
      end else begin
        amp = 0;
        seg = adsr_pkg::SEG_SILENT;
      end
      lvl.amplitude = amp[adsr_pkg::AMP_BITS-1:0];
      lvl.segment = seg;
      expected_levels = {expected_levels, lvl};
      items_in++;
    endfunction

    // compare a result with the oldest expected level
    function void check_result(adsr_pkg::out_item_t got);
      adsr_pkg::out_item_t lvl;
      bit ok;
      ok = 1'b1;
      if (expected_levels.size() == 0) begin
        $error("result with nothing expected: amplitude %0d segment %0d",
               got.amplitude, got.segment);
        mismatches++;
        return;
      end
      lvl = expected_levels.pop_front();
      if (got.amplitude !== lvl.amplitude) begin
        $error("amplitude mismatch: expected %0d, got %0d", lvl.amplitude, got.amplitude);
        ok = 1'b0;
      end
      if (got.segment !== lvl.segment) begin
        $error("segment mismatch: expected %0d, got %0d", lvl.segment, got.segment);
        ok = 1'b0;
      end
      if (ok) begin
        results_ok++;
        seg_seen[lvl.segment]++;
      end else begin
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_levels.size();
    endfunction
  endclass

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  adsr_pkg::in_item_t                 in_data = '0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  adsr_pkg::out_item_t                out_data;
  logic                               cfg_we = 1'b0;
  logic [adsr_pkg::CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [adsr_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

  envelope_scoreboard envelope_sb;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic [31:0] tick_now = '0;
  int unsigned settings_used = 1;

  adsr_envelope_generator_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

  // result side: check accepted results, stall at random
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) envelope_sb.check_result(out_data);
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // offer one item, with a random gap first, and wait for it to be taken
  task automatic send_item(logic [1:0] f, logic [31:0] stamp);
    int gap;
    adsr_pkg::in_item_t it;
    gap = 0;
    while (gap < 12 && $urandom_range(99) < send_idle_pct) gap++;
    it.func = f;
    it.time_tick = stamp;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    envelope_sb.note_input(it);
  endtask

  // hold off input until every expected result has come
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (envelope_sb.pending() != 0);
  endtask

  // write all four registers on consecutive cycles while the unit is idle
  task automatic apply_settings(logic [23:0] atk, logic [23:0] dec, logic [23:0] sus,
                                logic [23:0] rel);
    logic [23:0] vals[4];
    vals = '{atk, dec, sus, rel};
    drain();
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= adsr_pkg::cfg_reg_t'(i);
      cfg_data <= vals[i];
      @(posedge clk);
      envelope_sb.write_reg(adsr_pkg::cfg_reg_t'(i), vals[i]);
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // time step scaled to the whole envelope length
  function automatic logic [31:0] time_step();
    longint unsigned span;
    span = envelope_sb.attack_len + envelope_sb.decay_len + envelope_sb.release_len;
    case ($urandom_range(9))
      0: return '0;
      1: return 32'd1;
      2, 3: return $urandom_range(0, int'(span / 8) + 1);
      4, 5, 6, 7: return $urandom_range(0, int'(span / 3) + 1);
      8: return $urandom_range(0, int'(span));
      default: return $urandom_range(0, int'(2 * span));
    endcase
  endfunction

  // a note: on, queries, off, queries; sometimes broken or replaced by noise
  task automatic play_note();
    int n;
    if ($urandom_range(99) < 15) begin
      send_item(2'($urandom_range(3)), $urandom());
      return;
    end
    tick_now += time_step();
    if ($urandom_range(9) != 0) send_item(adsr_pkg::FUNC_NOTE_ON, tick_now);
    n = $urandom_range(1, 6);
    repeat (n) begin
      tick_now += time_step();
      send_item(adsr_pkg::FUNC_QUERY, tick_now);
    end
    tick_now += time_step();
    if ($urandom_range(9) != 0) send_item(adsr_pkg::FUNC_NOTE_OFF, tick_now);
    n = $urandom_range(1, 6);
    repeat (n) begin
      tick_now += time_step();
      send_item(($urandom_range(19) == 0) ? FUNC_SPARE : adsr_pkg::FUNC_QUERY, tick_now);
    end
  endtask

  function automatic logic [23:0] rand_duration();
    case ($urandom_range(7))
      0: return '0;
      1, 2: return 24'($urandom_range(1, 16));
      3, 4, 5: return 24'($urandom_range(1, 3000));
      default: return 24'($urandom_range(0, 24'hFFFFFF));
    endcase
  endfunction

  // main sequence
  initial begin
    int unsigned send_pct[4];
    int unsigned recv_pct[4];
    logic [23:0] preset[6][4];
    int unsigned phase_start, wait_cycles;
    send_pct = '{0, 52, 0, 36};
    recv_pct = '{0, 0, 52, 36};
    preset = '{
      '{24'd1, 24'd1, 24'd0, 24'd1},
      '{24'hFFFFFF, 24'hFFFFFF, 24'd65536, 24'hFFFFFF},
      '{24'd0, 24'd0, 24'h01FFFF, 24'd0},
      '{24'd100, 24'd50, 24'hFE8000, 24'd7},
      '{24'd37, 24'd1000, 24'd65535, 24'd5},
      '{24'd441, 24'd441, 24'd52429, 24'd441}
    };
    envelope_sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed items at the reset settings
    send_item(adsr_pkg::FUNC_QUERY, 32'd0);
    send_item(adsr_pkg::FUNC_QUERY, 32'd100);
    send_item(adsr_pkg::FUNC_QUERY, 32'hFFFF_FFFF);
    send_item(adsr_pkg::FUNC_NOTE_ON, 32'd1000);
    send_item(adsr_pkg::FUNC_QUERY, 32'd1220);
    send_item(adsr_pkg::FUNC_QUERY, 32'd1441);
    send_item(adsr_pkg::FUNC_QUERY, 32'd1700);
    send_item(adsr_pkg::FUNC_QUERY, 32'd1882);
    send_item(adsr_pkg::FUNC_QUERY, 32'd6000);
    send_item(FUNC_SPARE, 32'd7000);
    send_item(adsr_pkg::FUNC_NOTE_OFF, 32'd8000);
    send_item(adsr_pkg::FUNC_QUERY, 32'd8200);
    send_item(adsr_pkg::FUNC_QUERY, 32'd8440);
    send_item(adsr_pkg::FUNC_QUERY, 32'd8441);
    // note off during decay: release still starts from sustain
    send_item(adsr_pkg::FUNC_NOTE_ON, 32'd10000);
    send_item(adsr_pkg::FUNC_NOTE_OFF, 32'd10600);
    send_item(adsr_pkg::FUNC_QUERY, 32'd10700);
    send_item(adsr_pkg::FUNC_QUERY, 32'd10890);
    // time going backwards looks like a long elapsed time
    send_item(adsr_pkg::FUNC_QUERY, 32'd500);
    // note spanning the wrap of the time stamp
    send_item(adsr_pkg::FUNC_NOTE_ON, 32'hFFFF_FF00);
    send_item(adsr_pkg::FUNC_QUERY, 32'h0000_0010);
    send_item(adsr_pkg::FUNC_NOTE_OFF, 32'h0000_0400);
    send_item(adsr_pkg::FUNC_QUERY, 32'h0000_0500);
    tick_now = 32'h0000_1000;

    // random phases over idling modes and settings
    for (int p = 0; p < 12; p++) begin
      if (p < 6) apply_settings(preset[p][0], preset[p][1], preset[p][2], preset[p][3]);
      else begin
        apply_settings(rand_duration(), rand_duration(),
                       ($urandom_range(3) == 0) ? 24'($urandom_range(0, 24'hFFFFFF))
                                                : 24'($urandom_range(0, 65536)),
                       rand_duration());
      end
      send_idle_pct = send_pct[p % 4];
      recv_stall_pct = recv_pct[p % 4];
      phase_start = envelope_sb.items_in;
      while (envelope_sb.items_in - phase_start < 150) begin
        play_note();
        // a full pause after each note that leaves the item count mid phase
        if (envelope_sb.items_in - phase_start >= 75 &&
            envelope_sb.items_in - phase_start < 85) drain();
      end
    end

    // wind down
    in_valid <= 1'b0;
    recv_stall_pct = 0;
    wait_cycles = 0;
    while (envelope_sb.pending() != 0 && wait_cycles < 10000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (40) @(posedge clk);
    if (envelope_sb.pending() != 0) begin
      $error("%0d expected results never arrived", envelope_sb.pending());
      envelope_sb.mismatches++;
    end

    $display("%0d items over %0d register settings, %0d results matched", envelope_sb.items_in,
             settings_used, envelope_sb.results_ok);
    $display("segments seen: attack %0d, decay %0d, sustain %0d, release %0d, silent %0d",
             envelope_sb.seg_seen[0], envelope_sb.seg_seen[1], envelope_sb.seg_seen[2],
             envelope_sb.seg_seen[3], envelope_sb.seg_seen[4]);
    if (envelope_sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
